[sv/dleu_pkg.sv]
`default_nettype none

package dleu_pkg;

	// Default number of entries in the block buffer (raw block length).
	localparam int BLOCK_DEPTH_DEF = 40;

	// GSM framing: a 38-byte block whose bytes 2 to 34 carry the payload.
	localparam int GSM_BLOCK_LEN = 38;
	localparam int GSM_FIRST     = 2;
	localparam int GSM_PAYLOAD   = 33;
	localparam int GSM_LAST      = GSM_FIRST + GSM_PAYLOAD - 1;

	// Escape codes that follow the escape character.
	localparam logic [7:0] CODE_BUSY = 8'h62;
	localparam logic [7:0] CODE_DIAL = 8'h64;

	// Result kinds.
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_BUSY = 2'd1;
	localparam logic [1:0] KIND_DIAL = 2'd2;

	// Register file decode: register index is byte address bit 2.
	localparam int         PADDR_W      = 3;
	localparam logic       REG_DLE_CODE = 1'b0;
	localparam logic       REG_GSM_MODE = 1'b1;
	localparam logic [7:0] DLE_CODE_RST = 8'h10;
	localparam logic       GSM_MODE_RST = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // input transfer completes this cycle
		logic rd_en;      // read the block buffer at the read pointer
		logic load_data;  // move the read data into the output register
	} dleu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic emit_start; // the offered byte completes a block
		logic at_last;    // read pointer sits on the final payload byte
		logic out_free;   // output register can take a new result this cycle
	} dleu_sts_t;

endpackage

`default_nettype wire

[sv/dleu_ctrl.sv]
`default_nettype none

module dleu_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  dleu_pkg::dleu_sts_t sts,
	output dleu_pkg::dleu_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_LOAD = 3'b100
	} dleu_state_t;

	dleu_state_t state_q;
	dleu_state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_stall      = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall   = !sts.out_free;
				cmd.accept = in_valid && sts.out_free;
				if (cmd.accept && sts.emit_start) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_LOAD;
			end
			S_LOAD: begin
				if (sts.out_free) begin
					cmd.load_data = 1'b1;
					state_d       = sts.at_last ? S_IDLE : S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// A block buffer read is always followed by a load attempt.
	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> state_q == S_LOAD)
		else $error("read not followed by load state");
	// No input transfer while a block is being emitted.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !cmd.accept)
		else $error("input accepted during emission");
	// A stalled load keeps waiting in place.
	a_load_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD && !sts.out_free |=> state_q == S_LOAD)
		else $error("load state left while output busy");
`endif

endmodule

`default_nettype wire

[sv/dleu_dp.sv]
`default_nettype none

module dleu_dp #(
	parameter int BLOCK_DEPTH = dleu_pkg::BLOCK_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [7:0]          dle_code,
	input  wire                 gsm_mode,
	input  wire  [7:0]          rx_byte,
	input  dleu_pkg::dleu_cmd_t cmd,
	output dleu_pkg::dleu_sts_t sts,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [1:0]          kind,
	output logic [7:0]          data_byte,
	output logic                last_of_block
);

	localparam int ADDR_W = $clog2(BLOCK_DEPTH);
	localparam int FILL_W = $clog2(BLOCK_DEPTH + 1);

	logic              esc_q;
	logic [FILL_W-1:0] fill_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [ADDR_W-1:0] last_addr_q;
	logic [7:0]        rdata_q;
	logic [7:0]        mem [BLOCK_DEPTH];

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        data_q;
	logic              last_q;

	logic              is_dle;
	logic              do_store;
	logic              do_event;
	logic [1:0]        event_kind;
	logic              has_room;
	logic [FILL_W-1:0] fill_next;
	logic [FILL_W-1:0] block_len;
	logic              wr_en;

	// Escape handling for the offered byte.
	always_comb begin
		is_dle     = (rx_byte == dle_code);
		do_store   = 1'b0;
		do_event   = 1'b0;
		event_kind = dleu_pkg::KIND_BUSY;
		if (esc_q) begin
			if (is_dle) begin
				do_store = 1'b1;
			end else if (rx_byte == dleu_pkg::CODE_BUSY) begin
				do_event = 1'b1;
			end else if (rx_byte == dleu_pkg::CODE_DIAL) begin
				do_event   = 1'b1;
				event_kind = dleu_pkg::KIND_DIAL;
			end
		end else begin
			do_store = !is_dle;
		end
	end

	assign has_room  = (fill_q < FILL_W'(BLOCK_DEPTH));
	assign fill_next = has_room ? fill_q + FILL_W'(1) : fill_q;
	assign block_len = gsm_mode ? FILL_W'(dleu_pkg::GSM_BLOCK_LEN) : FILL_W'(BLOCK_DEPTH);
	assign wr_en     = cmd.accept && do_store && has_room;

	assign sts.emit_start = do_store && (fill_next >= block_len);
	assign sts.at_last    = (rd_addr_q == last_addr_q);
	assign sts.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			fill_q <= '0;
		end else if (cmd.accept) begin
			esc_q <= !esc_q && is_dle;
			if (do_store) begin
				fill_q <= sts.emit_start ? '0 : fill_next;
			end
		end
	end

	// Read pointer and end of the block being emitted.
	always_ff @(posedge clk) begin
		if (cmd.accept && sts.emit_start) begin
			rd_addr_q   <= gsm_mode ? ADDR_W'(dleu_pkg::GSM_FIRST) : '0;
			last_addr_q <= gsm_mode ? ADDR_W'(dleu_pkg::GSM_LAST) : ADDR_W'(BLOCK_DEPTH - 1);
		end else if (cmd.load_data) begin
			rd_addr_q <= rd_addr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[ADDR_W-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr_q];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.accept && do_event) || cmd.load_data) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_data) begin
			kind_q <= dleu_pkg::KIND_DATA;
			data_q <= rdata_q;
			last_q <= sts.at_last;
		end else if (cmd.accept && do_event) begin
			kind_q <= event_kind;
			data_q <= '0;
			last_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign data_byte     = data_q;
	assign last_of_block = last_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(BLOCK_DEPTH))
		else $error("fill count beyond buffer depth");
	a_fill_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.emit_start |=> fill_q == '0)
		else $error("fill count not cleared at block end");
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> kind_q == dleu_pkg::KIND_DATA)
		else $error("last flag on an event result");
	a_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != dleu_pkg::KIND_DATA |-> data_q == 8'd0)
		else $error("event result carries data");
`endif

endmodule

`default_nettype wire

[sv/voice_dle_unstuff_block_deframer_top.sv]
`default_nettype none

// DLE-shielded voice stream deframer. Received modem bytes arrive one per input
// transfer on rx_byte. The escape character (register dle_code, reset 0x10) is
// removed: a doubled escape gives one data byte, an escape followed by 'b' gives
// a busy result (kind 1), an escape followed by 'd' gives a dial tone result
// (kind 2), and any other escape code is dropped silently. Data bytes collect in
// an internal block buffer. When gsm_mode is 1 (reset), every 38 data bytes
// produce 33 output transfers carrying bytes 2 to 34 of the block; when gsm_mode
// is 0, every BLOCK_DEPTH data bytes are all sent out. The last payload byte of
// a block has last_of_block set. Events never interrupt the block; a partial
// block is held until it completes and is never flushed. Timing: outside of
// block emission a byte is taken every cycle as long as the output register is
// free or draining. Once a byte completes a block, the input stalls while the
// block is read out of the buffer RAM, each byte in a read step followed by an
// output load step; a load waits while the output is stalled.
// Registers sit on the APB port at byte address 0 (dle_code) and 4 (gsm_mode);
// they may only be written while no block is being emitted.

module voice_dle_unstuff_block_deframer_top #(
	parameter int BLOCK_DEPTH = dleu_pkg::BLOCK_DEPTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [dleu_pkg::PADDR_W-1:0]   paddr,
	input  wire  [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [7:0]                     rx_byte,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [1:0]                     kind,
	output logic [7:0]                     data_byte,
	output logic                           last_of_block
);

	logic [7:0]          dle_code_q;
	logic                gsm_mode_q;
	logic                cfg_wr;
	dleu_pkg::dleu_cmd_t cmd;
	dleu_pkg::dleu_sts_t sts;

	// The port never inserts wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Register index is taken from address bit 2; low address bits are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dle_code_q <= dleu_pkg::DLE_CODE_RST;
			gsm_mode_q <= dleu_pkg::GSM_MODE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				dleu_pkg::REG_DLE_CODE: dle_code_q <= pwdata[7:0];
				dleu_pkg::REG_GSM_MODE: gsm_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			dleu_pkg::REG_DLE_CODE: prdata = {24'd0, dle_code_q};
			dleu_pkg::REG_GSM_MODE: prdata = {31'd0, gsm_mode_q};
			default:                prdata = '0;
		endcase
	end

	// The controller sequences input transfers and block read-out.
	dleu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the escape state, block buffer and output register.
	dleu_dp #(
		.BLOCK_DEPTH (BLOCK_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.dle_code      (dle_code_q),
		.gsm_mode      (gsm_mode_q),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.last_of_block (last_of_block)
	);

`ifndef SYNTHESIS
	a_stall_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> in_stall)
		else $error("input not stalled during block read-out");
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr |=> $stable(dle_code_q) && $stable(gsm_mode_q))
		else $error("register changed without a write");
	a_single_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.load_data))
		else $error("two output sources in one cycle");
`endif

endmodule

`default_nettype wire
